/* hdl/hpg_pkg.sv */
// Shared constants, types and elaboration-time helpers for the Halton point generator.
// Used by hpg_lane and halton_point_generator; depends on nothing else.
package hpg_pkg;

  localparam int unsigned DEF_FRAC_BITS  = 32;
  localparam int unsigned DEF_NUM_BASES  = 6;
  localparam int unsigned DEF_MAX_DIGITS = 32;

  localparam int unsigned NUM_COORDS = 6;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIMS_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // wide enough for 13 * (2^64 + 1)
  localparam int unsigned PW = 72;

  localparam int unsigned PRIME [NUM_COORDS] = '{2, 3, 5, 7, 11, 13};

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 1'd1;

  localparam logic [IDX_W-1:0]  NUM_POINTS_RST = 32'd1024;
  localparam logic [DIMS_W-1:0] NUM_DIMS_RST   = 3'd3;

  typedef struct packed {
    logic start;   // item accepted: clear accumulator, arm carry
    logic clear;   // digits of this pass read as zero
    logic step;    // process one digit
  } hpg_lane_ctl_t;

  // b^e, saturated just above 2^fb (any larger power gives a zero weight)
  function automatic logic [PW-1:0] cap_pow(input int unsigned b, input int unsigned e,
                                            input int unsigned fb);
    logic [PW-1:0] p;
    logic [PW-1:0] lim;
    p   = PW'(1);
    lim = PW'(1) << fb;
    for (int unsigned i = 0; i < e; i++) begin
      p = p * PW'(b);
      if (p > lim) begin
        p = lim + PW'(1);
      end
    end
    return p;
  endfunction

endpackage

/* hdl/hpg_lane.sv */
// One base of the generator: digit ring for the index, weight table, serial accumulator.
// Depends on hpg_pkg.
module hpg_lane #(
  parameter int unsigned FRAC_BITS  = hpg_pkg::DEF_FRAC_BITS,
  parameter int unsigned MAX_DIGITS = hpg_pkg::DEF_MAX_DIGITS,
  parameter int unsigned BASE       = 2
) (
  input  logic                             clk,
  input  hpg_pkg::hpg_lane_ctl_t           ctl,
  input  logic [$clog2(MAX_DIGITS)-1:0]    dig_idx,
  output logic [hpg_pkg::COORD_W-1:0]      coord
);
  import hpg_pkg::*;

  localparam int unsigned PROD_W = FRAC_BITS + DIGIT_W;
  localparam int unsigned EXT_W  = FRAC_BITS + COORD_W;
  localparam logic [PW-1:0] FULL = PW'(1) << FRAC_BITS;

  logic [DIGIT_W-1:0]   ring_r   [MAX_DIGITS];
  logic [DIGIT_W-1:0]   ring_nxt [MAX_DIGITS];
  logic [FRAC_BITS-1:0] wgt_tab  [MAX_DIGITS];
  logic [FRAC_BITS-1:0] acc_r;
  logic                 carry_r;
  logic                 clr_r;

  logic [DIGIT_W-1:0]   head;
  logic [DIGIT_W:0]     inc;
  logic                 wrap;
  logic [DIGIT_W-1:0]   new_d;
  logic [PROD_W-1:0]    prod;
  logic [EXT_W-1:0]     acc_ext;

  // weight j = floor(2^FRAC_BITS / BASE^(j+1)), fixed at elaboration
  for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_wgt
    localparam logic [PW-1:0] POW = cap_pow(BASE, j + 1, FRAC_BITS);
    localparam logic [PW-1:0] WGT = FULL / POW;
    assign wgt_tab[j] = WGT[FRAC_BITS-1:0];
  end

  always_comb begin
    head  = clr_r ? '0 : ring_r[0];
    inc   = {1'b0, head} + (DIGIT_W+1)'(1);
    wrap  = (inc >= (DIGIT_W+1)'(BASE));
    new_d = carry_r ? (wrap ? '0 : inc[DIGIT_W-1:0]) : head;
    prod  = PROD_W'(new_d) * PROD_W'(wgt_tab[dig_idx]);
    for (int i = 0; i < MAX_DIGITS - 1; i++) begin
      ring_nxt[i] = ring_r[i+1];
    end
    ring_nxt[MAX_DIGITS-1] = new_d;
  end

  // ring rotates once per pass, least significant digit at the head
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r   <= '0;
      carry_r <= 1'b1;
      clr_r   <= ctl.clear;
    end else if (ctl.step) begin
      ring_r  <= ring_nxt;
      acc_r   <= acc_r + prod[FRAC_BITS-1:0];
      carry_r <= carry_r & wrap;
    end
  end

  assign acc_ext = EXT_W'(acc_r);
  assign coord   = acc_ext[COORD_W-1:0];

endmodule

/* hdl/halton_point_generator.sv */
// Halton point generator: each accepted request yields the next Halton point, index from 1 up.
// A point passes through ST_IDLE, which takes the request, then ST_RUN, which handles one digit of
// every base per cycle as the per-base digit rings rotate through the increment-with-carry and the
// weighted accumulate, then ST_FINISH, which loads the output register once it is empty or not stalled.
// The next request is taken while a finished point still waits in the output register.
// Coordinates are 0.32 fractions; bases at or past num_dims read zero. After the point whose
// index equals num_points (or index 2^32-1) last_point is set and the next point is index 1;
// in_restart does the same before the point it comes with. Write num_points/num_dims only idle.
// Depends on hpg_pkg and hpg_lane.
module halton_point_generator #(
  parameter int unsigned FRAC_BITS  = hpg_pkg::DEF_FRAC_BITS,
  parameter int unsigned NUM_BASES  = hpg_pkg::DEF_NUM_BASES,
  parameter int unsigned MAX_DIGITS = hpg_pkg::DEF_MAX_DIGITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base2,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base3,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base5,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base7,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base11,
  output logic [hpg_pkg::COORD_W-1:0]       out_coord_base13,
  output logic [hpg_pkg::IDX_W-1:0]         out_point_index,
  output logic                              out_last_point
);
  import hpg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } hpg_state_t;

  hpg_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    dig_cnt_r;
  logic [IDX_W-1:0]    index_r;
  logic                wrap_r;
  logic [IDX_W-1:0]    num_points_r;
  logic [DIMS_W-1:0]   num_dims_r;
  logic                out_valid_r;
  logic [COORD_W-1:0]  out_coord_r [NUM_COORDS];
  logic [IDX_W-1:0]    out_index_r;
  logic                out_last_r;
  logic                last_r;

  logic                in_xfer;
  logic                out_free;
  logic                seq_clear;
  logic [IDX_W-1:0]    index_nxt;
  logic                last_nxt;
  hpg_lane_ctl_t       lane_ctl;
  logic [COORD_W-1:0]  lane_coord [NUM_COORDS];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  // a wrap after the previous point acts like a restart
  assign seq_clear = in_restart || wrap_r;
  assign index_nxt = (seq_clear ? '0 : index_r) + IDX_W'(1);
  assign last_nxt  = (index_nxt == num_points_r) || (index_nxt == '1);

  assign lane_ctl.start = in_xfer;
  assign lane_ctl.clear = seq_clear;
  assign lane_ctl.step  = (state_r == ST_RUN);

  for (genvar k = 0; k < NUM_COORDS; k++) begin : g_lane
    if (k < NUM_BASES) begin : g_used
      hpg_lane #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_DIGITS (MAX_DIGITS),
        .BASE       (PRIME[k])
      ) u_lane (
        .clk     (clk),
        .ctl     (lane_ctl),
        .dig_idx (dig_cnt_r),
        .coord   (lane_coord[k])
      );
    end else begin : g_unused
      assign lane_coord[k] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (dig_cnt_r == CNT_LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dig_cnt_r    <= '0;
      index_r      <= '0;
      wrap_r       <= 1'b1;
      num_points_r <= NUM_POINTS_RST;
      num_dims_r   <= NUM_DIMS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        dig_cnt_r <= '0;
        index_r   <= index_nxt;
        wrap_r    <= last_nxt;
      end else if (state_r == ST_RUN) begin
        dig_cnt_r <= dig_cnt_r + CNT_W'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_POINTS: num_points_r <= cfg_wdata[IDX_W-1:0];
          REG_NUM_DIMS:   num_dims_r   <= cfg_wdata[DIMS_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_r <= last_nxt;
    end
    if (state_r == ST_FINISH && out_free) begin
      for (int k = 0; k < NUM_COORDS; k++) begin
        out_coord_r[k] <= (DIMS_W'(k) < num_dims_r) ? lane_coord[k] : '0;
      end
      out_index_r <= index_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coord_base2  = out_coord_r[0];
  assign out_coord_base3  = out_coord_r[1];
  assign out_coord_base5  = out_coord_r[2];
  assign out_coord_base7  = out_coord_r[3];
  assign out_coord_base11 = out_coord_r[4];
  assign out_coord_base13 = out_coord_r[5];
  assign out_point_index  = out_index_r;
  assign out_last_point   = out_last_r;

  a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_RUN) && (dig_cnt_r == '0))
    else $error("accepted item did not start a digit pass");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared without a finished pass");

  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_point_index != '0))
    else $error("point index zero on output");

  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_point) |->
      ((out_point_index == num_points_r) || (out_point_index == '1)))
    else $error("last flag on a point that does not end the sequence");

  a_wrap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && wrap_r) |=> (index_r == IDX_W'(1)))
    else $error("sequence did not wrap to index one");

endmodule
